[rtl/fsa_pkg.sv]
// -----------------------------------------------------------------------------
// Frame stack sum accumulator package
// Shared widths, register indexes, sample format codes and the pipeline stage type.
// -----------------------------------------------------------------------------
package fsa_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int INDEX_W          = 16;
   localparam int FMT_W            = 2;
   localparam int FRAMES_W         = 16;
   localparam int PPF_W            = 17;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 17;
   localparam int MAX_FRAME_PIXELS = 65536;
   localparam int ADDR_W           = $clog2(MAX_FRAME_PIXELS);

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_FORMAT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_TO_STACK  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXELS_PER_FRAME = 2'd2;

   localparam logic [FMT_W-1:0] FMT_8BIT   = 2'd0;
   localparam logic [FMT_W-1:0] FMT_16BIT_LE = 2'd1;
   localparam logic [FMT_W-1:0] FMT_16BIT_BE = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]   slot;
      logic [SAMPLE_W-1:0] sample;
      logic [FMT_W-1:0]    fmt;
      logic                first_frame;
      logic                last_pixel;
      logic                emit;
   } stage_type;

   function automatic logic [SAMPLE_W-1:0] swap_bytes(input logic [SAMPLE_W-1:0] v);
      swap_bytes = {v[7:0], v[15:8]};
   endfunction

endpackage

[rtl/fsa_if.sv]
// -----------------------------------------------------------------------------
// Frame stack sum accumulator channels
// Valid/ready channels for sample items and sum items.
// -----------------------------------------------------------------------------
interface fsa_req_if import fsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_bytes;

   modport source(output valid, output sample_bytes, input ready);
   modport sink(input valid, input sample_bytes, output ready);
endinterface

interface fsa_rsp_if import fsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sum_bytes;
   logic [INDEX_W-1:0]  pixel_index;
   logic                frame_end;

   modport source(output valid, output sum_bytes, output pixel_index, output frame_end,
                  input ready);
   modport sink(input valid, input sum_bytes, input pixel_index, input frame_end,
                output ready);
endinterface

[rtl/frame_stack_sum_accumulator.sv]
// -----------------------------------------------------------------------------
// Frame stack sum accumulator
// Sums a stack of frames pixel by pixel in a one-read, one-write sum memory.
// -----------------------------------------------------------------------------
// The block takes one pixel sample item per clock unless the output stalls and,
// during the last frame of a stack, returns one sum item per sample through the
// read-modify-write stage and the output register. While a sum item waits at
// the output, one more sample item can enter before the input stalls.
// Each item does a read-modify-write of its pixel's entry in a 65536-entry
// memory with a registered read; when two consecutive items hit the same
// pixel (a one-pixel frame) the new sum is forwarded around the memory. The
// memory is not cleared after reset: the first frame of each stack loads it.
module frame_stack_sum_accumulator import fsa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   fsa_req_if.sink                req_chan,
   fsa_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   logic [FMT_W-1:0]    fmt_ff;
   logic [FRAMES_W-1:0] frames_ff;
   logic [PPF_W-1:0]    ppf_ff;

   logic [INDEX_W-1:0]  pos_ff, pos_in;
   logic [FRAMES_W-1:0] frame_ff, frame_in;

   logic                s1_valid_ff, s1_valid_in;
   stage_type           s1_ff, s1_in;
   logic [SAMPLE_W-1:0] mem_q_ff;
   logic                fwd_ff;
   logic [SAMPLE_W-1:0] fwd_data_ff;

   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_sum_ff;
   logic [INDEX_W-1:0]  out_index_ff;
   logic                out_end_ff;

   logic [SAMPLE_W-1:0] sum_mem [0:MAX_FRAME_PIXELS-1];

   logic                accept;
   logic                out_free;
   logic                s1_adv;
   logic                out_load;
   logic [PPF_W-1:0]    frame_len;
   logic [FRAMES_W:0]   frame_cnt;
   logic [INDEX_W-1:0]  pos_clamp;
   logic                last_pixel;
   logic                last_frame;
   logic [SAMPLE_W-1:0] sample;
   logic [SAMPLE_W-1:0] operand;
   logic [SAMPLE_W-1:0] sum_full;
   logic [SAMPLE_W-1:0] sum_wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_8BIT;
         frames_ff <= FRAMES_W'(1);
         ppf_ff    <= PPF_W'(MAX_FRAME_PIXELS);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_FORMAT:    fmt_ff    <= csr_wr_data[FMT_W-1:0];
            CSR_FRAMES_TO_STACK:  frames_ff <= csr_wr_data[FRAMES_W-1:0];
            CSR_PIXELS_PER_FRAME: ppf_ff    <= csr_wr_data[PPF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ppf_ff == '0) begin
         frame_len = PPF_W'(1);
      end else if (ppf_ff > PPF_W'(MAX_FRAME_PIXELS)) begin
         frame_len = PPF_W'(MAX_FRAME_PIXELS);
      end else begin
         frame_len = ppf_ff;
      end
      frame_cnt = (frames_ff == '0) ? (FRAMES_W+1)'(1) : {1'b0, frames_ff};

      if ({1'b0, pos_ff} >= frame_len) begin
         pos_clamp = INDEX_W'(frame_len - PPF_W'(1));
      end else begin
         pos_clamp = pos_ff;
      end
      last_pixel = ({1'b0, pos_clamp} + PPF_W'(1)) >= frame_len;
      last_frame = ({1'b0, frame_ff} + (FRAMES_W+1)'(1)) >= frame_cnt;

      case (fmt_ff)
         FMT_16BIT_LE: sample = req_chan.sample_bytes;
         FMT_16BIT_BE: sample = swap_bytes(req_chan.sample_bytes);
         default:      sample = {8'h00, req_chan.sample_bytes[7:0]};
      endcase
   end

   always_comb begin
      out_free = !out_valid_ff || rsp_chan.ready;
      s1_adv   = !s1_ff.emit || out_free;
      req_chan.ready = !s1_valid_ff || s1_adv;
      accept   = req_chan.valid && req_chan.ready;
      out_load = s1_valid_ff && s1_adv && s1_ff.emit;

      s1_in.slot        = ADDR_W'(pos_clamp);
      s1_in.sample      = sample;
      s1_in.fmt         = fmt_ff;
      s1_in.first_frame = (frame_ff == '0);
      s1_in.last_pixel  = last_pixel;
      s1_in.emit        = last_frame;

      if (last_pixel) begin
         pos_in   = '0;
         frame_in = last_frame ? '0 : frame_ff + FRAMES_W'(1);
      end else begin
         pos_in   = pos_clamp + INDEX_W'(1);
         frame_in = frame_ff;
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      operand  = fwd_ff ? fwd_data_ff : mem_q_ff;
      sum_full = s1_ff.first_frame ? s1_ff.sample : operand + s1_ff.sample;
      case (s1_ff.fmt)
         FMT_16BIT_LE, FMT_16BIT_BE: sum_wrap = sum_full;
         default:                    sum_wrap = {8'h00, sum_full[7:0]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frame_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff   <= pos_in;
            frame_ff <= frame_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         mem_q_ff    <= sum_mem[s1_in.slot];
         fwd_ff      <= s1_valid_ff && (s1_ff.slot == s1_in.slot);
         fwd_data_ff <= sum_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         sum_mem[s1_ff.slot] <= sum_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_sum_ff   <= (s1_ff.fmt == FMT_16BIT_BE) ? swap_bytes(sum_wrap) : sum_wrap;
         out_index_ff <= INDEX_W'(s1_ff.slot);
         out_end_ff   <= s1_ff.last_pixel;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.sum_bytes   = out_sum_ff;
   assign rsp_chan.pixel_index = out_index_ff;
   assign rsp_chan.frame_end   = out_end_ff;

   a_accept_needs_free_stage: assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff |-> s1_adv)
      else $error("item accepted while the read-modify-write stage is stalled");

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("emitted sum did not reach the output register");

   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && last_pixel |=> pos_ff == '0)
      else $error("pixel position did not return to zero after the last pixel");

   a_pixel_steps: assert property (@(posedge clock) disable iff (reset)
      accept && !last_pixel |=> pos_ff != '0)
      else $error("pixel position did not advance within a frame");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Frame stack sum accumulator testbench
// Streams pixel sample items through the accumulator while both channels idle
// at random outside a steady window. Registers change between stacks and, once
// the block has gone quiet, in the middle of a stack. A scoreboard keeps its
// own copy of the per-pixel sums and checks every sum item in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fsa_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int PIPE_CYCLES   = 4;
   localparam int STALL_PCT     = 17;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 1120;
   localparam int BIG_AT        = 300;
   localparam int BIG_PIXELS    = 256;
   localparam int STEADY_FROM   = 500;
   localparam int STEADY_TO     = 800;
   localparam int STACK_ITEMS   = 240;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sum_bytes;
      logic [INDEX_W-1:0]  pixel_index;
      logic                frame_end;
   } sum_item_type;

   class stack_scoreboard;
      logic [FMT_W-1:0]    fmt;
      logic [FRAMES_W-1:0] frames;
      logic [PPF_W-1:0]    ppf;
      logic [SAMPLE_W-1:0] sums [MAX_FRAME_PIXELS];
      bit                  written [MAX_FRAME_PIXELS];
      int unsigned         written_prefix;
      int unsigned         position;
      int unsigned         frame_count;
      sum_item_type        expected [$];
      int unsigned         errors;

      function void clear();
         fmt = FMT_8BIT;
         frames = FRAMES_W'(1);
         ppf = PPF_W'(MAX_FRAME_PIXELS);
         position = 0;
         frame_count = 0;
         written_prefix = 0;
         foreach (written[i]) written[i] = 1'b0;
         expected.delete();
         errors = 0;
      endfunction

      function int unsigned len_of(input logic [PPF_W-1:0] v);
         int unsigned n;
         n = v;
         if (n == 0) n = 1;
         if (n > MAX_FRAME_PIXELS) n = MAX_FRAME_PIXELS;
         return n;
      endfunction

      // Growing the frame inside a stack must not reach pixels never loaded.
      function logic [PPF_W-1:0] safe_ppf(input logic [PPF_W-1:0] v);
         if (frame_count == 0 || len_of(v) <= written_prefix) return v;
         return PPF_W'(written_prefix);
      endfunction

      function bit at_stack_start();
         return position == 0 && frame_count == 0;
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction

      function void set_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_FORMAT:    fmt = data[FMT_W-1:0];
            CSR_FRAMES_TO_STACK:  frames = data[FRAMES_W-1:0];
            CSR_PIXELS_PER_FRAME: ppf = data[PPF_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(input logic [SAMPLE_W-1:0] raw);
         int unsigned         len;
         int unsigned         nframes;
         int unsigned         pos;
         logic [SAMPLE_W-1:0] sample;
         logic [SAMPLE_W-1:0] total;
         bit                  wide;
         bit                  last_pixel;
         bit                  last_frame;
         sum_item_type        item;
         len = len_of(ppf);
         nframes = (frames == 0) ? 1 : frames;
         pos = (position >= len) ? len - 1 : position;
         wide = (fmt == FMT_16BIT_LE || fmt == FMT_16BIT_BE);
         if (fmt == FMT_16BIT_LE) begin
            sample = raw;
         end else if (fmt == FMT_16BIT_BE) begin
            sample = {raw[7:0], raw[15:8]};
         end else begin
            sample = {8'h00, raw[7:0]};
         end
         total = (frame_count == 0) ? sample : sums[pos] + sample;
         if (!wide) total[15:8] = 8'h00;
         sums[pos] = total;
         written[pos] = 1'b1;
         while (written_prefix < MAX_FRAME_PIXELS && written[written_prefix])
            written_prefix++;
         last_pixel = (pos + 1 >= len);
         last_frame = (frame_count + 1 >= nframes);
         if (last_frame) begin
            item.sum_bytes = (fmt == FMT_16BIT_BE) ? {total[7:0], total[15:8]} : total;
            item.pixel_index = pos[INDEX_W-1:0];
            item.frame_end = last_pixel;
            expected.push_back(item);
         end
         if (last_pixel) begin
            position = 0;
            frame_count = last_frame ? 0 : frame_count + 1;
         end else begin
            position = pos + 1;
         end
      endfunction

      function void check_sum(input sum_item_type got);
         sum_item_type want;
         if (expected.size() == 0) begin
            errors++;
            $error("sum item with nothing expected: sum_bytes %h pixel_index %0d",
                   got.sum_bytes, got.pixel_index);
            return;
         end
         want = expected.pop_front();
         if (got.sum_bytes !== want.sum_bytes) begin
            errors++;
            $error("sum_bytes: expected %h, got %h", want.sum_bytes, got.sum_bytes);
         end
         if (got.pixel_index !== want.pixel_index) begin
            errors++;
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
         end
         if (got.frame_end !== want.frame_end) begin
            errors++;
            $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   bit                     steady = 1'b0;
   int unsigned            idle_cycles = 0;
   int unsigned            random_sent = 0;
   stack_scoreboard        board;

   fsa_req_if req_link();
   fsa_rsp_if rsp_link();

   frame_stack_sum_accumulator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_link),
      .rsp_chan    (rsp_link),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_link.ready <= 1'b0;
      end else begin
         if (rsp_link.valid && rsp_link.ready)
            board.check_sum(sum_item_type'{rsp_link.sum_bytes, rsp_link.pixel_index,
                                           rsp_link.frame_end});
         rsp_link.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] raw);
      while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
         req_link.valid <= 1'b0;
         @(posedge clock);
      end
      req_link.valid <= 1'b1;
      req_link.sample_bytes <= raw;
      do @(posedge clock); while (!req_link.ready);
      board.note_sample(raw);
   endtask

   // Frames that are not the last of a stack return nothing, so an empty
   // queue alone does not prove the pipeline is empty.
   task automatic drain_sums();
      req_link.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      board.set_reg(idx, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] fmt_data,
                             input logic [CSR_DATA_W-1:0] frames_data,
                             input logic [CSR_DATA_W-1:0] ppf_data);
      drain_sums();
      write_reg(CSR_SAMPLE_FORMAT, fmt_data);
      write_reg(CSR_FRAMES_TO_STACK, frames_data);
      write_reg(CSR_PIXELS_PER_FRAME, ppf_data);
   endtask

   function automatic logic [CSR_DATA_W-1:0] with_noise(input logic [CSR_DATA_W-1:0] value,
                                                        input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
      return value | (junk << width);
   endfunction

   function automatic logic [FRAMES_W-1:0] random_frames();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return FRAMES_W'(0);
      if (r < 80) return FRAMES_W'($urandom_range(1, 4));
      if (r < 95) return FRAMES_W'($urandom_range(5, 12));
      return FRAMES_W'($urandom_range(13, 40));
   endfunction

   function automatic logic [PPF_W-1:0] random_ppf();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return PPF_W'(0);
      if (r < 75) return PPF_W'($urandom_range(1, 8));
      if (r < 95) return PPF_W'($urandom_range(9, 40));
      return PPF_W'($urandom_range(41, 200));
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return SAMPLE_W'($urandom_range(0, 255));
         3: return {8'($urandom), 8'hFF};
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic change_one_reg();
      logic [CSR_INDEX_W-1:0] idx;
      idx = CSR_INDEX_W'($urandom_range(0, 2));
      case (idx)
         CSR_SAMPLE_FORMAT:
            write_reg(idx, with_noise(CSR_DATA_W'($urandom_range(0, 3)), FMT_W));
         CSR_FRAMES_TO_STACK:
            write_reg(idx, with_noise(CSR_DATA_W'(random_frames()), FRAMES_W));
         default:
            write_reg(CSR_PIXELS_PER_FRAME, board.safe_ppf(random_ppf()));
      endcase
   endtask

   task automatic run_stack(input bit big);
      logic [FMT_W-1:0]    fmt;
      logic [FRAMES_W-1:0] nframes;
      logic [PPF_W-1:0]    ppf;
      int unsigned         len;
      int unsigned         count;
      int unsigned         brk;
      fmt = FMT_W'($urandom_range(0, 3));
      if (big) begin
         nframes = FRAMES_W'(1);
         ppf = PPF_W'(BIG_PIXELS);
      end else begin
         nframes = random_frames();
         ppf = board.safe_ppf(random_ppf());
      end
      len = board.len_of(ppf);
      if (!big && nframes * len > STACK_ITEMS) nframes = FRAMES_W'(STACK_ITEMS / len);
      set_config(with_noise(CSR_DATA_W'(fmt), FMT_W),
                 with_noise(CSR_DATA_W'(nframes), FRAMES_W), ppf);
      brk = (!big && $urandom_range(0, 99) < 15) ? $urandom_range(1, 30) : 0;
      count = 0;
      do begin
         push_sample(random_sample());
         count++;
         if (!big) random_sent++;
         steady = random_sent >= STEADY_FROM && random_sent < STEADY_TO;
         if (count == brk && !board.at_stack_start()) begin
            drain_sums();
            change_one_reg();
         end
      end while (!board.at_stack_start());
   endtask

   initial begin
      bit big_done;
      board = new();
      board.clear();
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_SAMPLE_FORMAT;
      csr_wr_data <= '0;
      req_link.valid <= 1'b0;
      req_link.sample_bytes <= '0;
      big_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 8-bit samples, one frame of the full length.
      push_sample(16'h0000);
      push_sample(16'hFFFF);
      push_sample(16'h00FF);
      push_sample(16'hFF00);
      push_sample(16'h8001);

      // Unknown format, zero frames and zero length, set mid-frame.
      drain_sums();
      write_reg(CSR_SAMPLE_FORMAT, 17'h1FFFF);
      write_reg(CSR_FRAMES_TO_STACK, 17'h10000);
      write_reg(CSR_PIXELS_PER_FRAME, 17'h00000);
      write_reg(CSR_UNMAPPED, 17'h15A5A);
      push_sample(16'h1234);
      push_sample(16'hABCD);
      push_sample(16'h00FF);

      // 16-bit little endian sums that wrap.
      set_config(CSR_DATA_W'(FMT_16BIT_LE), CSR_DATA_W'(3), CSR_DATA_W'(2));
      push_sample(16'hFFFF);
      push_sample(16'h0001);
      push_sample(16'hFFFF);
      push_sample(16'h0001);
      push_sample(16'h8000);
      push_sample(16'h8000);

      // 16-bit big endian: swapped on the way in and on the way out.
      set_config(CSR_DATA_W'(FMT_16BIT_BE), CSR_DATA_W'(2), CSR_DATA_W'(2));
      push_sample(16'h0102);
      push_sample(16'h00FF);
      push_sample(16'h0201);
      push_sample(16'h0100);

      // Largest frame count, then cut short within the stack.
      set_config(CSR_DATA_W'(FMT_8BIT), 17'h0FFFF, CSR_DATA_W'(1));
      push_sample(16'hAAFF);
      push_sample(16'h55FF);
      push_sample(16'h00FF);
      drain_sums();
      write_reg(CSR_FRAMES_TO_STACK, 17'h00002);
      push_sample(16'h0180);

      // Oversized length saturates to the store size.
      set_config(CSR_DATA_W'(FMT_16BIT_LE), CSR_DATA_W'(1), 17'h1FFFF);
      push_sample(16'h7FFF);
      push_sample(16'hFFFE);

      while (random_sent < RANDOM_ITEMS) begin
         if (!big_done && random_sent >= BIG_AT) begin
            run_stack(1'b1);
            big_done = 1'b1;
         end else begin
            run_stack(1'b0);
         end
      end
      steady = 1'b0;
      drain_sums();

      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
